>>> design/qts_pkg.sv
// ----------------------------------------------------------------------------
// Quoted token splitter package
// Shared types and constants for the token splitter: result kinds, the
// result record and the bundle of up to three results caused by one request.
// ----------------------------------------------------------------------------
package qts_pkg;

   localparam int COUNT_W     = 7;
   localparam int MAX_RESULTS = 3;

   localparam logic [COUNT_W-1:0] TOKEN_LIMIT       = 7'd64;
   localparam logic [COUNT_W-1:0] MAX_TOKENS_RESET  = 7'd64;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   typedef enum logic [1:0] {
      KIND_BYTE      = 2'd0,
      KIND_TOKEN_END = 2'd1,
      KIND_DONE      = 2'd2,
      KIND_ERROR     = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [7:0]           out_byte;
      logic [COUNT_W-1:0]   token_count;
   } result_type;

   typedef struct packed {
      logic [1:0]                     count;
      result_type [MAX_RESULTS-1:0]   res;
   } bundle_type;

endpackage

>>> design/qts_req_if.sv
// ----------------------------------------------------------------------------
// Token splitter request channel
// Valid/ready channel carrying one line byte or the end-of-line marker.
// ----------------------------------------------------------------------------
interface qts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_line;

   modport source (output valid, ch, end_of_line, input ready);
   modport sink   (input valid, ch, end_of_line, output ready);
endinterface

>>> design/qts_rsp_if.sv
// ----------------------------------------------------------------------------
// Token splitter result channel
// Valid/ready channel carrying one result: kind, byte, count and last flag.
// ----------------------------------------------------------------------------
interface qts_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic [6:0] token_count;
   logic       last;

   modport source (output valid, kind, out_byte, token_count, last, input ready);
   modport sink   (input valid, kind, out_byte, token_count, last, output ready);
endinterface

>>> design/qts_decode.sv
// ----------------------------------------------------------------------------
// Token splitter decode
// Scan state, token count and limit register; works out, for the request at
// the input, the bundle of results it causes and the next scan state.
// ----------------------------------------------------------------------------
module qts_decode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [qts_pkg::COUNT_W-1:0] csr_data,
   input  logic                        in_valid,
   input  logic [7:0]                  in_ch,
   input  logic                        in_eol,
   input  logic                        space,
   output logic                        push,
   output qts_pkg::bundle_type         bundle
);
   import qts_pkg::*;

   typedef enum logic [2:0] {
      MODE_BETWEEN  = 3'd0,
      MODE_TOKEN    = 3'd1,
      MODE_TOKEN_BS = 3'd2,
      MODE_QUOTE    = 3'd3,
      MODE_QUOTE_BS = 3'd4,
      MODE_DROP     = 3'd5
   } mode_type;

   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] seen_ff, seen_in;
   logic [COUNT_W-1:0] max_tokens_ff;
   logic [COUNT_W-1:0] limit;
   logic               accept;
   logic               is_space;

   assign accept   = in_valid && space;
   assign push     = accept && (bundle.count != 2'd0);
   assign limit    = (max_tokens_ff < TOKEN_LIMIT) ? max_tokens_ff : TOKEN_LIMIT;
   assign is_space = (in_ch == CH_SPACE) || ((in_ch >= 8'd9) && (in_ch <= 8'd13));

   always_comb begin
      mode_in = mode_ff;
      seen_in = seen_ff;
      bundle  = '0;
      if (in_eol) begin
         mode_in = MODE_BETWEEN;
         seen_in = '0;
         case (mode_ff)
            MODE_TOKEN_BS: begin
               bundle.count = 2'd3;
               bundle.res[0].kind        = KIND_BYTE;
               bundle.res[0].out_byte    = CH_BACKSLASH;
               bundle.res[1].kind        = KIND_TOKEN_END;
               bundle.res[2].kind        = KIND_DONE;
               bundle.res[2].token_count = seen_ff;
            end
            MODE_TOKEN: begin
               bundle.count = 2'd2;
               bundle.res[0].kind        = KIND_TOKEN_END;
               bundle.res[1].kind        = KIND_DONE;
               bundle.res[1].token_count = seen_ff;
            end
            MODE_QUOTE, MODE_QUOTE_BS: begin
               bundle.count = 2'd1;
               bundle.res[0].kind = KIND_ERROR;
            end
            default: begin
               bundle.count = 2'd1;
               bundle.res[0].kind        = KIND_DONE;
               bundle.res[0].token_count = seen_ff;
            end
         endcase
      end else if (in_ch != 8'd0) begin
         case (mode_ff)
            MODE_BETWEEN, MODE_TOKEN: begin
               if (is_space) begin
                  if (mode_ff == MODE_TOKEN) begin
                     bundle.count = 2'd1;
                     bundle.res[0].kind = KIND_TOKEN_END;
                     mode_in = MODE_BETWEEN;
                  end
               end else if ((mode_ff == MODE_BETWEEN) && (seen_ff >= limit)) begin
                  mode_in = MODE_DROP;
               end else begin
                  if (mode_ff == MODE_BETWEEN) begin
                     seen_in = seen_ff + 7'd1;
                  end
                  if (in_ch == CH_QUOTE) begin
                     mode_in = MODE_QUOTE;
                  end else if (in_ch == CH_BACKSLASH) begin
                     mode_in = MODE_TOKEN_BS;
                  end else begin
                     mode_in = MODE_TOKEN;
                     bundle.count = 2'd1;
                     bundle.res[0].kind     = KIND_BYTE;
                     bundle.res[0].out_byte = in_ch;
                  end
               end
            end
            MODE_TOKEN_BS: begin
               if ((in_ch == CH_SPACE) || (in_ch == CH_QUOTE) || (in_ch == CH_BACKSLASH)) begin
                  bundle.count = 2'd1;
                  bundle.res[0].kind     = KIND_BYTE;
                  bundle.res[0].out_byte = in_ch;
                  mode_in = MODE_TOKEN;
               end else begin
                  bundle.count = 2'd2;
                  bundle.res[0].kind     = KIND_BYTE;
                  bundle.res[0].out_byte = CH_BACKSLASH;
                  if (is_space) begin
                     bundle.res[1].kind = KIND_TOKEN_END;
                     mode_in = MODE_BETWEEN;
                  end else begin
                     bundle.res[1].kind     = KIND_BYTE;
                     bundle.res[1].out_byte = in_ch;
                     mode_in = MODE_TOKEN;
                  end
               end
            end
            MODE_QUOTE: begin
               if (in_ch == CH_QUOTE) begin
                  mode_in = MODE_TOKEN;
               end else if (in_ch == CH_BACKSLASH) begin
                  mode_in = MODE_QUOTE_BS;
               end else begin
                  bundle.count = 2'd1;
                  bundle.res[0].kind     = KIND_BYTE;
                  bundle.res[0].out_byte = in_ch;
               end
            end
            MODE_QUOTE_BS: begin
               mode_in = MODE_QUOTE;
               if ((in_ch != CH_QUOTE) && (in_ch != CH_BACKSLASH)) begin
                  bundle.count = 2'd2;
                  bundle.res[0].kind     = KIND_BYTE;
                  bundle.res[0].out_byte = CH_BACKSLASH;
                  bundle.res[1].kind     = KIND_BYTE;
                  bundle.res[1].out_byte = in_ch;
               end else begin
                  bundle.count = 2'd1;
                  bundle.res[0].kind     = KIND_BYTE;
                  bundle.res[0].out_byte = in_ch;
               end
            end
            MODE_DROP: begin
               mode_in = MODE_DROP;
            end
            default: begin
               mode_in = MODE_BETWEEN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_BETWEEN;
         seen_ff       <= '0;
         max_tokens_ff <= MAX_TOKENS_RESET;
      end else begin
         if (csr_we) begin
            max_tokens_ff <= csr_data;
         end
         if (accept) begin
            mode_ff <= mode_in;
            seen_ff <= seen_in;
         end
      end
   end

`ifndef SYNTH
   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && in_eol) |=> (mode_ff == MODE_BETWEEN) && (seen_ff == '0))
      else $error("scan state not cleared after end of line");

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= TOKEN_LIMIT)
      else $error("token count above hard limit");

   a_zero_byte_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && !in_eol && (in_ch == 8'd0)) |=> $stable(mode_ff) && $stable(seen_ff))
      else $error("zero byte changed scan state");
`endif

endmodule

>>> design/qts_serializer.sv
// ----------------------------------------------------------------------------
// Token splitter result serialiser
// Holds the bundle of one request and hands its results out one per cycle
// while they are taken, flagging the final one.
// ----------------------------------------------------------------------------
module qts_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qts_pkg::bundle_type bundle,
   output logic                space,
   output logic                out_valid,
   input  logic                out_ready,
   output qts_pkg::result_type out_res,
   output logic                out_last
);
   import qts_pkg::*;

   logic                         valid_ff;
   logic [1:0]                   count_ff;
   logic [1:0]                   idx_ff;
   result_type [MAX_RESULTS-1:0] res_ff;
   logic                         take;

   assign out_valid = valid_ff;
   assign out_res   = res_ff[idx_ff];
   assign out_last  = (idx_ff == (count_ff - 2'd1));
   assign take      = valid_ff && out_ready;
   assign space     = !valid_ff || (take && out_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
         count_ff <= '0;
      end else if (push) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
         count_ff <= bundle.count;
      end else if (take) begin
         if (out_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         res_ff <= bundle.res;
      end
   end

`ifndef SYNTH
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < count_ff))
      else $error("result index beyond bundle");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> space)
      else $error("bundle loaded over pending results");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (take && !out_last) |=> valid_ff && (idx_ff == $past(idx_ff) + 2'd1))
      else $error("result index failed to advance");
`endif

endmodule

>>> design/quoted_token_splitter_unit.sv
// ----------------------------------------------------------------------------
// Quoted token splitter
// Shell-style line tokeniser: bytes in, token bytes, token ends and a
// line-done or unterminated-quote result out.
// ----------------------------------------------------------------------------
// A request is taken in the cycle it is offered whenever the result register
// is empty or is handing over its final result, so requests that cause at
// most one result (the usual case) flow at one per cycle while results are
// taken as they appear. A request causing n results (n up to 3) occupies the
// three-slot result register until its last result is taken, which drains
// one result per cycle while taken; the next request, even one causing no
// result, is held meanwhile. Results appear in the cycle after their request.
// The token limit register may be written only while no results are pending.
module quoted_token_splitter_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [qts_pkg::COUNT_W-1:0] csr_data,
   qts_req_if.sink                     req_bus,
   qts_rsp_if.source                   rsp_bus
);
   import qts_pkg::*;

   logic       space;
   logic       push;
   bundle_type bundle;
   result_type rsp_res;

   // Request side: accept only while the result register has room.
   assign req_bus.ready = space;

   qts_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_data (csr_data),
      .in_valid (req_bus.valid),
      .in_ch    (req_bus.ch),
      .in_eol   (req_bus.end_of_line),
      .space    (space),
      .push     (push),
      .bundle   (bundle)
   );

   // Result side: hold the bundle and advance through it as results are taken.
   qts_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .bundle    (bundle),
      .space     (space),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_res   (rsp_res),
      .out_last  (rsp_bus.last)
   );

   assign rsp_bus.kind        = rsp_res.kind;
   assign rsp_bus.out_byte    = rsp_res.out_byte;
   assign rsp_bus.token_count = rsp_res.token_count;

endmodule

>>> sim/tb_quoted_token_splitter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted token splitter testbench
// Streams text lines into the splitter through a queue-fed driver, predicts
// every token byte, token end and line result in step with each accepted
// request, and checks the result channel under random idling on both sides
// across several token limit settings.
// ----------------------------------------------------------------------------
module tb_quoted_token_splitter_unit;
   import qts_pkg::*;

   localparam int IDLE_PCT       = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASE_ITEMS    = 18;

   // Tokeniser position within the current line.
   typedef enum logic [2:0] {
      SCAN_BETWEEN   = 3'd0,
      SCAN_TOKEN     = 3'd1,
      SCAN_TOKEN_ESC = 3'd2,
      SCAN_QUOTE     = 3'd3,
      SCAN_QUOTE_ESC = 3'd4,
      SCAN_DROP      = 3'd5
   } scan_state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eol;
   } line_item_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         out_byte;
      logic [COUNT_W-1:0] token_count;
      logic               last;
   } split_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [COUNT_W-1:0]  csr_data;

   qts_req_if req_bus ();
   qts_rsp_if rsp_bus ();

   quoted_token_splitter_unit dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_data (csr_data),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus)
   );

   // Requests waiting for the driver, and results the splitter still owes.
   line_item_type    pending_chars[$];
   split_result_type owed_results[$];
   split_result_type step_results[$];

   // Predictor state: a private copy of the tokeniser and its register.
   scan_state_type     scan        = SCAN_BETWEEN;
   logic [COUNT_W-1:0] tokens_open = '0;
   logic [COUNT_W-1:0] token_limit = MAX_TOKENS_RESET;

   line_item_type    next_char;
   split_result_type got_result;
   split_result_type want_result;
   int               mismatches   = 0;
   int               chars_queued = 0;
   int               quiet_cycles = 0;
   bit               calm         = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------
   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic void add_result(kind_type kind, logic [7:0] b, logic [COUNT_W-1:0] n);
      split_result_type r;
      r.kind        = kind;
      r.out_byte    = b;
      r.token_count = n;
      r.last        = 1'b0;
      step_results.push_back(r);
   endfunction

   // A non-blank byte met outside quotes: open a quote, arm an escape, or emit.
   function automatic void take_token_char(logic [7:0] c);
      if (c == CH_QUOTE) begin
         scan = SCAN_QUOTE;
      end else if (c == CH_BACKSLASH) begin
         scan = SCAN_TOKEN_ESC;
      end else begin
         scan = SCAN_TOKEN;
         add_result(KIND_BYTE, c, '0);
      end
   endfunction

   // Work out every result one accepted request causes and queue them as owed.
   function automatic void predict_split(logic [7:0] c, logic eol);
      logic [COUNT_W-1:0] lim;
      step_results.delete();
      lim = (token_limit < TOKEN_LIMIT) ? token_limit : TOKEN_LIMIT;
      if (eol) begin
         case (scan)
            SCAN_TOKEN_ESC: begin
               // a trailing backslash outside quotes stays literal
               add_result(KIND_BYTE, CH_BACKSLASH, '0);
               add_result(KIND_TOKEN_END, 8'h00, '0);
               add_result(KIND_DONE, 8'h00, tokens_open);
            end
            SCAN_TOKEN: begin
               add_result(KIND_TOKEN_END, 8'h00, '0);
               add_result(KIND_DONE, 8'h00, tokens_open);
            end
            SCAN_QUOTE, SCAN_QUOTE_ESC: begin
               add_result(KIND_ERROR, 8'h00, '0);
            end
            default: begin
               add_result(KIND_DONE, 8'h00, tokens_open);
            end
         endcase
         scan        = SCAN_BETWEEN;
         tokens_open = '0;
      end else if (c != 8'h00) begin
         case (scan)
            SCAN_BETWEEN: begin
               if (!is_blank(c)) begin
                  if (tokens_open >= lim) begin
                     scan = SCAN_DROP;
                  end else begin
                     tokens_open = tokens_open + 7'd1;
                     take_token_char(c);
                  end
               end
            end
            SCAN_TOKEN: begin
               if (is_blank(c)) begin
                  add_result(KIND_TOKEN_END, 8'h00, '0);
                  scan = SCAN_BETWEEN;
               end else begin
                  take_token_char(c);
               end
            end
            SCAN_TOKEN_ESC: begin
               if (c == CH_SPACE || c == CH_QUOTE || c == CH_BACKSLASH) begin
                  add_result(KIND_BYTE, c, '0);
                  scan = SCAN_TOKEN;
               end else begin
                  add_result(KIND_BYTE, CH_BACKSLASH, '0);
                  if (is_blank(c)) begin
                     add_result(KIND_TOKEN_END, 8'h00, '0);
                     scan = SCAN_BETWEEN;
                  end else begin
                     add_result(KIND_BYTE, c, '0);
                     scan = SCAN_TOKEN;
                  end
               end
            end
            SCAN_QUOTE: begin
               if (c == CH_QUOTE) begin
                  scan = SCAN_TOKEN;
               end else if (c == CH_BACKSLASH) begin
                  scan = SCAN_QUOTE_ESC;
               end else begin
                  add_result(KIND_BYTE, c, '0);
               end
            end
            SCAN_QUOTE_ESC: begin
               if (c != CH_QUOTE && c != CH_BACKSLASH) begin
                  add_result(KIND_BYTE, CH_BACKSLASH, '0);
               end
               add_result(KIND_BYTE, c, '0);
               scan = SCAN_QUOTE;
            end
            default: begin
               // dropping the rest of the line
            end
         endcase
      end
      if (step_results.size() > 0) begin
         step_results[step_results.size()-1].last = 1'b1;
      end
      foreach (step_results[i]) begin
         owed_results.push_back(step_results[i]);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Request driver: predict on acceptance, then offer the next queued byte
   // unless this cycle is chosen to idle.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_split(req_bus.ch, req_bus.end_of_line);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_chars.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               next_char           = pending_chars.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.ch          <= next_char.ch;
               req_bus.end_of_line <= next_char.eol;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result monitor: compare each accepted result with the oldest owed one,
   // then pick the next cycle's ready at random.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_result.kind        = kind_type'(rsp_bus.kind);
            got_result.out_byte    = rsp_bus.out_byte;
            got_result.token_count = rsp_bus.token_count;
            got_result.last        = rsp_bus.last;
            if (owed_results.size() == 0) begin
               if (mismatches < 10) begin
                  $display("unexpected result: kind %0d byte %02h count %0d last %0d",
                           got_result.kind, got_result.out_byte,
                           got_result.token_count, got_result.last);
               end
               mismatches++;
            end else begin
               want_result = owed_results.pop_front();
               if (got_result !== want_result) begin
                  if (mismatches < 10) begin
                     $display("result mismatch: expected kind %0d byte %02h count %0d last %0d,",
                              want_result.kind, want_result.out_byte,
                              want_result.token_count, want_result.last);
                     $display("                 got      kind %0d byte %02h count %0d last %0d",
                              got_result.kind, got_result.out_byte,
                              got_result.token_count, got_result.last);
                  end
                  mismatches++;
               end
            end
         end
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Watchdog: give up when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("quoted_token_splitter_unit test failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic void push_char(logic [7:0] c, logic eol);
      line_item_type it;
      it.ch  = c;
      it.eol = eol;
      pending_chars.push_back(it);
      chars_queued++;
   endfunction

   // Bias token content towards quotes, escapes and other awkward bytes.
   function automatic logic [7:0] pick_token_char();
      int         r;
      logic [7:0] c;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         c = 8'($urandom_range(33, 126));
         if (c == CH_QUOTE || c == CH_BACKSLASH) c = 8'h7A;
      end else if (r < 57) begin
         c = CH_QUOTE;
      end else if (r < 69) begin
         c = CH_BACKSLASH;
      end else if (r < 75) begin
         c = CH_SPACE;
      end else if (r < 79) begin
         c = 8'($urandom_range(9, 13));
      end else if (r < 89) begin
         c = 8'($urandom_range(128, 255));
      end else if (r < 93) begin
         c = 8'h00;
      end else begin
         c = 8'($urandom_range(1, 31));
      end
      return c;
   endfunction

   // Separator: always one blank first, so tokens never merge by accident.
   function automatic void push_gap();
      if ($urandom_range(0, 4) < 4) push_char(CH_SPACE, 1'b0);
      else push_char(8'($urandom_range(9, 13)), 1'b0);
      if ($urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 1) == 0) push_char(8'h00, 1'b0);
         else push_char(8'($urandom_range(9, 13)), 1'b0);
      end
   endfunction

   // Well-formed line shape with random content; wide lines use one-letter
   // tokens so the token limit is reached without a huge request count.
   function automatic void push_line(int ntok);
      int len;
      if ($urandom_range(0, 3) == 0) push_gap();
      for (int k = 0; k < ntok; k++) begin
         if (ntok > 8) begin
            push_char(8'h61 + 8'(k % 26), 1'b0);
         end else begin
            len = $urandom_range(1, 5);
            for (int j = 0; j < len; j++) push_char(pick_token_char(), 1'b0);
         end
         if (k < ntok - 1) push_gap();
      end
      if ($urandom_range(0, 3) == 0) push_gap();
      push_char(8'($urandom_range(0, 255)), 1'b1);
   endfunction

   // Hold the sender until every owed result has come back, then let any
   // result-free request still inside the block finish.
   task automatic settle();
      while (pending_chars.size() != 0 || req_bus.valid || owed_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(int value);
      settle();
      csr_we      <= 1'b1;
      csr_data    <= value[COUNT_W-1:0];
      token_limit = value[COUNT_W-1:0];
      @(posedge clock);
      csr_we      <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      int limits[8];
      int phase_start;
      int noise_len;
      bit paused;

      req_bus.valid       = 1'b0;
      req_bus.ch          = 8'h00;
      req_bus.end_of_line = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_we              = 1'b0;
      csr_data            = '0;
      reset               = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Backslash at line end outside quotes: literal byte, token end, done.
      push_char(8'h61, 1'b0);
      push_char(CH_BACKSLASH, 1'b0);
      push_char(8'h00, 1'b1);
      // Line ends inside a quote with an escape pending: error only.
      push_char(CH_QUOTE, 1'b0);
      push_char(8'h71, 1'b0);
      push_char(CH_BACKSLASH, 1'b0);
      push_char(8'h5A, 1'b1);
      // Zero byte, escaped space, quote mid-token, escaped quote inside the
      // quote, top byte value, tab as separator.
      push_char(8'h00, 1'b0);
      push_char(CH_BACKSLASH, 1'b0);
      push_char(CH_SPACE, 1'b0);
      push_char(CH_QUOTE, 1'b0);
      push_char(CH_SPACE, 1'b0);
      push_char(CH_BACKSLASH, 1'b0);
      push_char(CH_QUOTE, 1'b0);
      push_char(CH_QUOTE, 1'b0);
      push_char(8'hFF, 1'b0);
      push_char(8'h09, 1'b0);
      push_char(8'hA5, 1'b1);
      // Zero limit: the whole line is dropped, count zero.
      write_limit(0);
      push_char(8'h61, 1'b0);
      push_char(8'hFF, 1'b1);
      // Limit of one: the second token and its quote are dropped.
      write_limit(1);
      push_char(8'h61, 1'b0);
      push_char(CH_SPACE, 1'b0);
      push_char(8'h62, 1'b0);
      push_char(CH_QUOTE, 1'b0);
      push_char(8'h00, 1'b1);

      // Random phases, one token limit each, extremes among them.
      limits = '{127, 64, 2, 3, 0, 65, 0, 1};
      limits[4] = $urandom_range(1, 10);
      limits[6] = $urandom_range(0, 127);
      paused = 1'b0;
      for (int p = 0; p < 8; p++) begin
         write_limit(limits[p]);
         // run one phase flat out with no idling on either side
         calm = (p == 2);
         // one line wider than the hard limit, under a register above it
         if (p == 0) push_line(70);
         phase_start = chars_queued;
         while (chars_queued - phase_start < PHASE_ITEMS) begin
            if (p == 4 && !paused && chars_queued - phase_start >= 10) begin
               settle();
               paused = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
               // noise line: raw bytes, often leaving a quote open
               noise_len = $urandom_range(3, 10);
               for (int j = 0; j < noise_len; j++) begin
                  push_char(8'($urandom_range(0, 255)), 1'b0);
               end
               push_char(8'($urandom_range(0, 255)), 1'b1);
            end else begin
               push_line($urandom_range(0, 6));
            end
         end
      end
      calm = 1'b0;

      settle();
      repeat (8) @(posedge clock);
      if (owed_results.size() != 0) begin
         $display("%0d results never arrived", owed_results.size());
      end
      if (mismatches == 0 && owed_results.size() == 0) begin
         $display("quoted_token_splitter_unit test passed");
      end else begin
         $display("quoted_token_splitter_unit test failed");
      end
      $finish;
   end

endmodule
